@@ hw/rtl/dels_pkg.sv @@
// dels_pkg: shared types and codes of the double-ended list store
// operation kinds, result status codes and the per-cell control struct
// no dependencies
`timescale 1ns / 1ps

package dels_pkg;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND_BACK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE_BACK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_INDEX  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    // control broadcast from the controller to every cell of the row
    typedef struct packed {
        logic push_front;   // shift the row toward the back, cell 0 takes the value
        logic pop_front;    // shift the row toward the front
        logic wr_back;      // the cell at the write index takes the value
        logic tap_load;     // copy every element into its tap
        logic tap_shift;    // move the taps one cell toward the front
    } t_cell_ctl;

endpackage

@@ hw/rtl/dels_cell.sv @@
// dels_cell: one storage cell of the element row
// holds one element and one tap register for indexed readout
// depends on dels_pkg
`timescale 1ns / 1ps

module dels_cell #(
    parameter int INDEX      = 0,
    parameter int ADDR_W     = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  dels_pkg::t_cell_ctl   i_ctl,
    input  logic [ADDR_W-1:0]     i_wr_idx,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic [DATA_WIDTH-1:0] i_next_tap,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);
    import dels_pkg::*;

    localparam logic [ADDR_W-1:0] MY_IDX = ADDR_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] r_tap;

    // element: shift in either direction, or take an appended value
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_front) begin
            r_data <= i_prev_data;
        end else if (i_ctl.pop_front) begin
            r_data <= i_next_data;
        end else if (i_ctl.wr_back && (i_wr_idx == MY_IDX)) begin
            r_data <= i_value;
        end
    end

    // tap: snapshot of the row that walks toward cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.tap_load) begin
            r_tap <= r_data;
        end else if (i_ctl.tap_shift) begin
            r_tap <= i_next_tap;
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

@@ hw/rtl/dels_ctrl.sv @@
// dels_ctrl: operation decode, fill count, tap walk sequencing and result stages
// drives the control broadcast of the cell row
// depends on dels_pkg
`timescale 1ns / 1ps

module dels_ctrl #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 8,
    parameter int CNT_W      = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dels_pkg::KIND_W-1:0]     i_kind,
    input  logic [DATA_WIDTH-1:0]           i_value,
    input  logic [dels_pkg::POS_W-1:0]      i_position,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dels_pkg::STATUS_W-1:0]   o_status,
    output logic [DATA_WIDTH-1:0]           o_data,
    output logic [CNT_W-1:0]                o_count,
    input  logic [DATA_WIDTH-1:0]           i_head_data,
    input  logic [DATA_WIDTH-1:0]           i_head_tap,
    output dels_pkg::t_cell_ctl             o_ctl,
    output logic [ADDR_W-1:0]               o_wr_idx,
    output logic [DATA_WIDTH-1:0]           o_value
);
    import dels_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEEK = 1'b1;

    logic                r_state, n_state;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;

    logic                r_res_valid, n_res_valid;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [DATA_WIDTH-1:0] r_res_data, n_res_data;
    logic [CNT_W-1:0]    r_res_count, n_res_count;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [DATA_WIDTH-1:0] r_out_data, n_out_data;
    logic [CNT_W-1:0]    r_out_count, n_out_count;

    logic                accept;
    logic                res_move;
    logic                is_full;
    logic                is_empty;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    fill_ext;
    logic [CNT_W-1:0]    last_cnt;
    logic [ADDR_W-1:0]   target;
    logic                want_seek;
    t_cell_ctl           ctl;

    assign res_move   = r_res_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE) && (!r_res_valid || res_move);
    assign accept     = i_in_valid && o_in_ready;

    assign is_full  = (r_fill == FULL_CNT);
    assign is_empty = (r_fill == '0);
    assign pos_ext  = CMP_W'(i_position);
    assign fill_ext = CMP_W'(r_fill);
    assign last_cnt = r_fill - CNT_W'(1);

    // decode, fill update, tap walk and result staging
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_cnt        = r_cnt;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_count  = r_res_count;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        ctl          = '0;
        target       = '0;
        want_seek    = 1'b0;

        // output register takes the staged result when free
        if (res_move) begin
            n_out_valid  = 1'b1;
            n_out_status = r_res_status;
            n_out_data   = r_res_data;
            n_out_count  = r_res_count;
            n_res_valid  = 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_res_status = STATUS_OK;
            n_res_data   = '0;
            unique case (i_kind)
                KIND_PUSH_FRONT: begin
                    if (is_full) begin
                        n_res_status = STATUS_FULL;
                    end else begin
                        ctl.push_front = 1'b1;
                        n_fill         = r_fill + CNT_W'(1);
                    end
                end
                KIND_APPEND_BACK: begin
                    if (is_full) begin
                        n_res_status = STATUS_FULL;
                    end else begin
                        ctl.wr_back = 1'b1;
                        n_fill      = r_fill + CNT_W'(1);
                    end
                end
                KIND_POP_FRONT: begin
                    if (is_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else begin
                        n_res_data    = i_head_data;
                        ctl.pop_front = 1'b1;
                        n_fill        = last_cnt;
                    end
                end
                KIND_REMOVE_BACK: begin
                    if (is_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else begin
                        target    = last_cnt[ADDR_W-1:0];
                        want_seek = 1'b1;
                        n_fill    = last_cnt;
                    end
                end
                KIND_READ_INDEX: begin
                    if (pos_ext >= fill_ext) begin
                        n_res_status = STATUS_RANGE;
                    end else begin
                        target    = pos_ext[ADDR_W-1:0];
                        want_seek = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_res_count = n_fill;

            // element at the front is read at once, deeper ones walk the taps
            if (want_seek && (target == '0)) begin
                n_res_data  = i_head_data;
                n_res_valid = 1'b1;
            end else if (want_seek) begin
                ctl.tap_load = 1'b1;
                n_cnt        = target;
                n_state      = ST_SEEK;
            end else begin
                n_res_valid = 1'b1;
            end
        end else if (r_state == ST_SEEK) begin
            if (r_cnt != '0) begin
                ctl.tap_shift = 1'b1;
                n_cnt         = r_cnt - ADDR_W'(1);
            end else begin
                n_res_valid  = 1'b1;
                n_res_status = STATUS_OK;
                n_res_data   = i_head_tap;
                n_res_count  = r_fill;
                n_state      = ST_IDLE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_count  <= n_res_count;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
    end

    assign o_ctl       = ctl;
    assign o_wr_idx    = r_fill[ADDR_W-1:0];
    assign o_value     = i_value;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data      = r_out_data;
    assign o_count     = r_out_count;

    // fill never passes capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count above capacity");

    // at most one element update per cycle
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.push_front, ctl.pop_front, ctl.wr_back}))
        else $error("conflicting element updates");

    // a tap snapshot always starts a walk
    a_load_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.tap_load |=> (r_state == ST_SEEK))
        else $error("tap load without walk");

    // no new item during a walk
    a_seek_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEEK) |-> !o_in_ready)
        else $error("input taken during walk");

    // staged result is kept until the output register takes it
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !res_move) |=> r_res_valid)
        else $error("staged result lost");

endmodule

@@ hw/rtl/double_ended_list_store.sv @@
// double_ended_list_store: bounded deque with indexed read, built as a row of cells
// instantiates dels_ctrl and DEPTH copies of dels_cell
// depends on dels_pkg
//
// usage:
//   slave channel s_axis carries one operation per item: kind in tuser, the value
//   and the read position in tdata. master channel m_axis returns exactly one
//   result per item: status in tuser, the element and the new count in tdata.
//   the front element always sits in cell 0; push and pop shift the whole row
//   by one cell, append writes the cell at the current count.
//   push, append, pop, a read at position 0 and a remove from a store holding
//   one element pass through the staged result register and then the output
//   register; such items can be taken one per cycle while the receiver is ready.
//   a read at position p > 0, and a remove from the back (p = count - 1), walk a
//   snapshot of the row toward cell 0 one cell per cycle; the input is held off
//   until the walk is done, and the result then passes through the staged result
//   register and the output register, so the tap walk of the row sets their cost.
//   reset empties the store at once (count zero); element cells are not cleared.
//   a stalled receiver holds the output register and one staged result; after
//   that s_axis_tready drops until m_axis_tready returns.
`timescale 1ns / 1ps

module double_ended_list_store #(
    parameter int DEPTH       = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int IN_W       = ((DATA_WIDTH + dels_pkg::POS_W + 7) / 8) * 8,
    localparam int OUT_W      = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // fields from bit 0: value, position
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // fields from bit 0: kind
    input  logic [dels_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fields from bit 0: data_out, count
    output logic [OUT_W-1:0]                m_axis_tdata,
    // fields from bit 0: status
    output logic [dels_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import dels_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_WIDTH-1:0] in_value;
    logic [POS_W-1:0]      in_position;
    logic [DATA_WIDTH-1:0] res_data;
    logic [CNT_W-1:0]      res_count;
    logic [DATA_WIDTH-1:0] bus_value;
    logic [ADDR_W-1:0]     wr_idx;
    t_cell_ctl             cell_ctl;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH];

    // unpack input payload
    assign in_value    = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_position = s_axis_tdata[DATA_WIDTH +: POS_W];

    dels_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_value     (in_value),
        .i_position  (in_position),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_data      (res_data),
        .o_count     (res_count),
        .i_head_data (w_data[0]),
        .i_head_tap  (w_tap[0]),
        .o_ctl       (cell_ctl),
        .o_wr_idx    (wr_idx),
        .o_value     (bus_value)
    );

    // row of cells, cell 0 holds the front element
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        logic [DATA_WIDTH-1:0] next_data;
        logic [DATA_WIDTH-1:0] next_tap;

        if (gi == 0) begin : g_first
            assign prev_data = bus_value;
        end else begin : g_inner_prev
            assign prev_data = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign next_data = '0;
            assign next_tap  = '0;
        end else begin : g_inner_next
            assign next_data = w_data[gi+1];
            assign next_tap  = w_tap[gi+1];
        end

        dels_cell #(
            .INDEX      (gi),
            .ADDR_W     (ADDR_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_wr_idx    (wr_idx),
            .i_value     (bus_value),
            .i_prev_data (prev_data),
            .i_next_data (next_data),
            .i_next_tap  (next_tap),
            .o_data      (w_data[gi]),
            .o_tap       (w_tap[gi])
        );
    end

    // pack result payload
    assign m_axis_tdata = OUT_W'({res_count, res_data});

endmodule
